FILE: src/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared types and constants for the 64-bit Miller-Rabin primality tester.
// ----------------------------------------------------------------------------
`default_nettype none

package mrpt_pkg;

    localparam int unsigned WordWidth = 64;
    localparam int unsigned BaseCount = 7;
    localparam int unsigned BaseIdxWidth = 3;

    typedef logic [WordWidth-1:0] word_t;

    // Request to the modular multiplier and its status back.
    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
        word_t m;
    } mul_req_t;

    typedef struct packed {
        logic  done;
        word_t prod;
    } mul_rsp_t;

    // Fixed set of seven witness bases.
    function automatic word_t base_value(input logic [BaseIdxWidth-1:0] idx);
        word_t val;
        begin
            case (idx)
                3'd0:    val = word_t'(2);
                3'd1:    val = word_t'(325);
                3'd2:    val = word_t'(9375);
                3'd3:    val = word_t'(28178);
                3'd4:    val = word_t'(450775);
                3'd5:    val = word_t'(9780504);
                3'd6:    val = word_t'(1794265022);
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/miller_rabin_prime_test_64.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64
// Miller-Rabin test of a 64-bit unsigned candidate with a fixed set of bases.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one candidate per transfer in tdata. m_axis returns one
//   transfer per candidate, with is_prime in tdata[0].
//   The block works on one candidate at a time: s_axis_tready is high only
//   while no test is running and no result is waiting.
//   Candidates below two, even candidates and three are answered in the cycle
//   after the input transfer.
//   Other odd candidates first strip the factors of two from n-1. Each base
//   is then reduced by repeated compare-and-subtract, followed by up to 128
//   products for the power (64 squarings and up to 64 multiplies) and up to
//   62 further squarings. Every product goes through the shared bit-serial
//   multiplier; a composite stops at the first failing base.
//   The result sits in the output register until m_axis_tready takes it;
//   a stalled receiver only holds the block in its done state.
//   Reset clears the sequencer; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module miller_rabin_prime_test_64
    import mrpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [63:0] candidate
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [0] is_prime, [7:1] zero
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SPLIT  = 10'b0000000010,
        ST_BASE   = 10'b0000000100,
        ST_REDUCE = 10'b0000001000,
        ST_PSQ    = 10'b0000010000,
        ST_PMUL   = 10'b0000100000,
        ST_CHECK  = 10'b0001000000,
        ST_SQR    = 10'b0010000000,
        ST_WAIT   = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t     state_reg, state_next;
    word_t      n_reg, n_next;
    word_t      d_reg, d_next;
    logic [5:0] s_reg, s_next;
    logic [5:0] r_reg, r_next;
    logic [6:0] bit_reg, bit_next;
    logic [BaseIdxWidth-1:0] base_reg, base_next;
    word_t      x_reg, x_next;
    word_t      a_reg, a_next;
    logic [4:0] red_reg, red_next;
    logic       pmul_reg, pmul_next;
    logic       res_reg, res_next;
    mul_req_t   req;
    mul_rsp_t   rsp;
    word_t      nm1;
    word_t      shifted;

    mrpt_mulmod u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    assign nm1     = n_reg - word_t'(1);
    assign shifted = n_reg << red_reg;

    // Sequencer: answer small and even candidates at once, else split n-1, then
    // for each base the reduction, the left-to-right power and the squaring chain.
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        base_next  = base_reg;
        x_next     = x_reg;
        a_next     = a_reg;
        red_next   = red_reg;
        pmul_next  = pmul_reg;
        res_next   = res_reg;
        req.start  = 1'b0;
        req.a      = x_reg;
        req.b      = x_reg;
        req.m      = n_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    n_next = s_axis_tdata;
                    if (s_axis_tdata < word_t'(2))
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (!s_axis_tdata[0])
                    begin
                        res_next   = (s_axis_tdata == word_t'(2));
                        state_next = ST_DONE;
                    end
                    else if (s_axis_tdata == word_t'(3))
                    begin
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        d_next     = s_axis_tdata - word_t'(1);
                        s_next     = '0;
                        base_next  = '0;
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT:
            begin
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + 6'd1;
                end
                else
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                if (base_reg == BaseIdxWidth'(BaseCount))
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    a_next     = base_value(base_reg);
                    red_next   = 5'd31;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                // Restoring reduction: bases fit in 31 bits.
                if ((n_reg >> (WordWidth - 1 - 31 + 1)) == '0 &&
                    (shifted >> red_reg) == n_reg && a_reg >= shifted)
                begin
                    a_next = a_reg - shifted;
                end
                if (red_reg == '0)
                begin
                    state_next = ST_CHECK;
                    pmul_next  = 1'b1;
                end
                else
                begin
                    red_next = red_reg - 5'd1;
                end
            end
            ST_CHECK:
            begin
                if (pmul_reg)
                begin
                    // Base reduced: start the power, or skip a zero base.
                    pmul_next = 1'b0;
                    if (a_reg == '0)
                    begin
                        base_next  = base_reg + BaseIdxWidth'(1);
                        state_next = ST_BASE;
                    end
                    else
                    begin
                        x_next     = word_t'(1);
                        bit_next   = 7'd63;
                        state_next = ST_PSQ;
                    end
                end
                else if (x_reg == word_t'(1) || x_reg == nm1)
                begin
                    base_next  = base_reg + BaseIdxWidth'(1);
                    state_next = ST_BASE;
                end
                else
                begin
                    r_next     = 6'd1;
                    state_next = ST_SQR;
                end
            end
            ST_PSQ:
            begin
                req.start  = 1'b1;
                pmul_next  = 1'b0;
                state_next = ST_WAIT;
            end
            ST_PMUL:
            begin
                req.start  = 1'b1;
                req.b      = a_reg;
                pmul_next  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_SQR:
            begin
                if (r_reg >= s_reg)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    req.start  = 1'b1;
                    bit_next   = 7'd64;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    x_next = rsp.prod;
                    if (bit_reg == 7'd64)
                    begin
                        if (rsp.prod == nm1)
                        begin
                            base_next  = base_reg + BaseIdxWidth'(1);
                            state_next = ST_BASE;
                        end
                        else
                        begin
                            r_next     = r_reg + 6'd1;
                            state_next = ST_SQR;
                        end
                    end
                    else if (!pmul_reg && d_reg[bit_reg[5:0]])
                    begin
                        state_next = ST_PMUL;
                    end
                    else if (bit_reg == '0)
                    begin
                        state_next = ST_CHECK;
                        pmul_next  = 1'b0;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 7'd1;
                        state_next = ST_PSQ;
                    end
                end
            end
            ST_DONE:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        d_reg    <= d_next;
        s_reg    <= s_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        base_reg <= base_next;
        x_reg    <= x_next;
        a_reg    <= a_next;
        red_reg  <= red_next;
        pmul_reg <= pmul_next;
        res_reg  <= res_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_DONE);
    assign m_axis_tdata  = {7'd0, res_reg};

`ifndef ASSERT_OFF
    // Never ready for input while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n) m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready with result pending");
    // Every start of the multiplier is followed by a wait for its product.
    assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> state_reg == ST_WAIT)
        else $error("multiplier started outside a wait");
    // Input ready is not held after a candidate is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready held after accept");
`endif

endmodule

`default_nettype wire

FILE: src/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// mrpt_mulmod
// Bit-serial modular multiplier: (a * b) mod m by double-and-add, one bit
// of b per cycle. Requires a < m and b < m.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_mulmod
    import mrpt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    word_t      acc_reg, acc_next;
    word_t      a_reg, a_next;
    word_t      b_reg, b_next;
    word_t      m_reg, m_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;

    word_t      dbl;
    word_t      sum;
    logic [WordWidth:0] wide;

    // One double-and-add step, each add reduced by one compare and subtract.
    always_comb
    begin
        wide = {1'b0, acc_reg} + {1'b0, acc_reg};
        dbl  = (wide >= {1'b0, m_reg}) ? WordWidth'(wide - {1'b0, m_reg})
                                       : wide[WordWidth-1:0];
        wide = {1'b0, dbl} + {1'b0, a_reg};
        sum  = (wide >= {1'b0, m_reg}) ? WordWidth'(wide - {1'b0, m_reg})
                                       : wide[WordWidth-1:0];
        if (!b_reg[WordWidth-1])
        begin
            sum = dbl;
        end
    end

    // Sequencing of the 64 steps.
    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
            m_next    = req.m;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum;
            b_next   = {b_reg[WordWidth-2:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

`ifndef ASSERT_OFF
    // Done is a single pulse that ends a busy period.
    assert property (@(posedge clk) disable iff (!rst_n) rsp.done |-> !busy_reg)
        else $error("mulmod done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) rsp.done |=> !rsp.done)
        else $error("mulmod done held");
    // The result stays reduced below the modulus.
    assert property (@(posedge clk) disable iff (!rst_n) rsp.done |-> rsp.prod < m_reg)
        else $error("mulmod result not reduced");
`endif

endmodule

`default_nettype wire
